>>> rtl/npc_pkg.sv
// Shared constants and types for the nearest palette color search.
package npc_pkg;

    localparam int PALETTE_DEPTH = 256;
    localparam int IDX_W         = 8;
    localparam int CNT_W         = 9;
    localparam int COLOR_W       = 8;
    localparam int SQ_W          = 16;
    localparam int DIST_W        = 29;
    localparam int S_DATA_W      = 32;
    localparam int M_DATA_W      = 40;

    localparam logic [DIST_W-1:0] W_R_SQ = DIST_W'(29 * 29);
    localparam logic [DIST_W-1:0] W_G_SQ = DIST_W'(59 * 59);
    localparam logic [DIST_W-1:0] W_B_SQ = DIST_W'(11 * 11);

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    typedef struct packed {
        logic               valid;
        logic [IDX_W-1:0]   tag;
        logic [COLOR_W-1:0] e_red;
        logic [COLOR_W-1:0] e_green;
        logic [COLOR_W-1:0] e_blue;
        logic [COLOR_W-1:0] q_red;
        logic [COLOR_W-1:0] q_green;
        logic [COLOR_W-1:0] q_blue;
    } dist_req_t;

    typedef struct packed {
        logic              valid;
        logic [IDX_W-1:0]  tag;
        logic [DIST_W-1:0] distance;
    } dist_res_t;

endpackage

>>> rtl/npc_dist_unit.sv
// Four-stage pipeline computing the weighted squared RGB distance of one entry.
module npc_dist_unit (
    input  logic                 clk,
    input  logic                 rst_n,
    input  npc_pkg::dist_req_t   req,
    output npc_pkg::dist_res_t   res
);

    logic [3:0] valid_reg;
    logic [npc_pkg::IDX_W-1:0] tag1_reg, tag2_reg, tag3_reg, tag4_reg;
    logic [npc_pkg::COLOR_W-1:0] dr_reg, dg_reg, db_reg;
    logic [npc_pkg::SQ_W-1:0] sr_reg, sg_reg, sb_reg;
    logic [npc_pkg::DIST_W-1:0] wr_reg, wg_reg, wb_reg;
    logic [npc_pkg::DIST_W-1:0] sum_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[2:0], req.valid};
        end
    end

    always_ff @(posedge clk)
    begin
        dr_reg   <= (req.e_red > req.q_red) ? req.e_red - req.q_red : req.q_red - req.e_red;
        dg_reg   <= (req.e_green > req.q_green) ? req.e_green - req.q_green
                                                : req.q_green - req.e_green;
        db_reg   <= (req.e_blue > req.q_blue) ? req.e_blue - req.q_blue
                                              : req.q_blue - req.e_blue;
        tag1_reg <= req.tag;

        sr_reg   <= npc_pkg::SQ_W'(dr_reg) * npc_pkg::SQ_W'(dr_reg);
        sg_reg   <= npc_pkg::SQ_W'(dg_reg) * npc_pkg::SQ_W'(dg_reg);
        sb_reg   <= npc_pkg::SQ_W'(db_reg) * npc_pkg::SQ_W'(db_reg);
        tag2_reg <= tag1_reg;

        wr_reg   <= npc_pkg::DIST_W'(sr_reg) * npc_pkg::W_R_SQ;
        wg_reg   <= npc_pkg::DIST_W'(sg_reg) * npc_pkg::W_G_SQ;
        wb_reg   <= npc_pkg::DIST_W'(sb_reg) * npc_pkg::W_B_SQ;
        tag3_reg <= tag2_reg;

        sum_reg  <= wr_reg + wg_reg + wb_reg;
        tag4_reg <= tag3_reg;
    end

    assign res.valid    = valid_reg[3];
    assign res.tag      = tag4_reg;
    assign res.distance = sum_reg;

endmodule

>>> rtl/nearest_palette_color.sv
// Top level of the nearest palette color search with its palette memory.
//
//  Channel   Direction  Signals                     Contents (lowest bit first)
//  s_*       in         tvalid tready tdata tuser   load or query transaction
//  m_*       out        tvalid tready tdata         one result per query
//  cfg_*     in         we wdata                    palette_count register
//
// A query with a count of n (capped at 256) scans the palette: the scan reads one
// palette memory entry per cycle and runs it through the four-stage distance
// pipeline. Counts of 0 or 1 skip the scan and go straight to the result.
// Reset clears the control state and sets palette_count to 256; the memory is
// not cleared. The input stalls during a scan and while a finished result
// cannot be moved into a full output register.
module nearest_palette_color (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // entry_index[7:0], red[15:8], green[23:16], blue[31:24]
    input  logic [npc_pkg::S_DATA_W-1:0]    s_tdata,
    // cmd[0]
    input  logic                            s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // nearest_index[7:0], best_distance_sq[36:8], zero[39:37]
    output logic [npc_pkg::M_DATA_W-1:0]    m_tdata,
    input  logic                            cfg_we,
    input  logic [npc_pkg::CNT_W-1:0]       cfg_wdata
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_DONE = 3'b100
    } state_t;

    state_t state_reg, state_next;

    logic [npc_pkg::CNT_W-1:0]   palette_count_reg;
    logic [23:0]                 palette_mem [npc_pkg::PALETTE_DEPTH];
    logic [23:0]                 rd_data_reg;
    logic                        rd_vld_reg;
    logic [npc_pkg::IDX_W-1:0]   rd_tag_reg;

    logic [npc_pkg::IDX_W-1:0]   addr_reg, addr_next;
    logic [npc_pkg::IDX_W-1:0]   last_reg, last_next;
    logic                        issue_reg, issue_next;
    logic                        found_reg, found_next;
    logic [npc_pkg::IDX_W-1:0]   best_idx_reg, best_idx_next;
    logic [npc_pkg::DIST_W-1:0]  best_dist_reg, best_dist_next;
    logic [npc_pkg::COLOR_W-1:0] q_red_reg, q_green_reg, q_blue_reg;

    logic                        m_tvalid_reg, m_tvalid_next;
    logic [npc_pkg::IDX_W-1:0]   out_idx_reg;
    logic [npc_pkg::DIST_W-1:0]  out_dist_reg;
    logic                        out_load;

    logic                        s_accept;
    logic [npc_pkg::CNT_W-1:0]   count_eff;

    npc_pkg::dist_req_t          req;
    npc_pkg::dist_res_t          res;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign count_eff = (palette_count_reg > npc_pkg::CNT_W'(npc_pkg::PALETTE_DEPTH))
                     ? npc_pkg::CNT_W'(npc_pkg::PALETTE_DEPTH) : palette_count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            palette_count_reg <= npc_pkg::CNT_W'(256);
        end
        else if (cfg_we)
        begin
            palette_count_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept && (s_tuser == npc_pkg::CMD_LOAD))
        begin
            palette_mem[s_tdata[7:0]] <= {s_tdata[15:8], s_tdata[23:16], s_tdata[31:24]};
        end
        rd_data_reg <= palette_mem[addr_reg];
        rd_tag_reg  <= addr_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            q_red_reg   <= s_tdata[15:8];
            q_green_reg <= s_tdata[23:16];
            q_blue_reg  <= s_tdata[31:24];
        end
        if (out_load)
        begin
            out_idx_reg  <= best_idx_reg;
            out_dist_reg <= best_dist_reg;
        end
    end

    assign req.valid   = rd_vld_reg;
    assign req.tag     = rd_tag_reg;
    assign req.e_red   = rd_data_reg[23:16];
    assign req.e_green = rd_data_reg[15:8];
    assign req.e_blue  = rd_data_reg[7:0];
    assign req.q_red   = q_red_reg;
    assign req.q_green = q_green_reg;
    assign req.q_blue  = q_blue_reg;

    npc_dist_unit u_dist (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .res   (res)
    );

    always_comb
    begin
        state_next     = state_reg;
        addr_next      = addr_reg;
        last_next      = last_reg;
        issue_next     = issue_reg;
        found_next     = found_reg;
        best_idx_next  = best_idx_reg;
        best_dist_next = best_dist_reg;
        out_load       = 1'b0;
        m_tvalid_next  = m_tvalid_reg && !m_tready;

        case (state_reg)
            ST_IDLE:
            begin
                if (s_accept && (s_tuser == npc_pkg::CMD_QUERY))
                begin
                    found_next     = 1'b0;
                    best_idx_next  = '0;
                    best_dist_next = '0;
                    addr_next      = '0;
                    last_next      = npc_pkg::IDX_W'(count_eff - npc_pkg::CNT_W'(2));
                    if (count_eff < npc_pkg::CNT_W'(2))
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        issue_next = 1'b1;
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                if (issue_reg)
                begin
                    addr_next = addr_reg + npc_pkg::IDX_W'(1);
                    if (addr_reg == last_reg)
                    begin
                        issue_next = 1'b0;
                    end
                end
                if (res.valid)
                begin
                    if (!found_reg || (res.distance < best_dist_reg))
                    begin
                        found_next     = 1'b1;
                        best_idx_next  = res.tag;
                        best_dist_next = res.distance;
                    end
                    if (res.tag == last_reg)
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_DONE:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    out_load      = 1'b1;
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            addr_reg      <= '0;
            last_reg      <= '0;
            issue_reg     <= 1'b0;
            found_reg     <= 1'b0;
            best_idx_reg  <= '0;
            best_dist_reg <= '0;
            rd_vld_reg    <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            addr_reg      <= addr_next;
            last_reg      <= last_next;
            issue_reg     <= issue_next;
            found_reg     <= found_next;
            best_idx_reg  <= best_idx_next;
            best_dist_reg <= best_dist_next;
            rd_vld_reg    <= issue_reg;
            m_tvalid_reg  <= m_tvalid_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {3'b000, out_dist_reg, out_idx_reg};

    // Distance results only arrive while a scan is running.
    a_res_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid |-> (state_reg == ST_SCAN))
        else $error("distance result outside of a scan");

    // The read address never runs past the last searched entry.
    a_addr_bound: assert property (@(posedge clk) disable iff (!rst_n)
        issue_reg |-> (addr_reg <= last_reg))
        else $error("scan address beyond the last searched entry");

    // Once a winner exists, its distance never grows during a scan.
    a_best_mono: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN && found_reg) |=> (best_dist_reg <= $past(best_dist_reg)))
        else $error("best distance increased");

    // A finished result waits while the output register is still occupied.
    a_done_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && m_tvalid_reg && !m_tready) |=> (state_reg == ST_DONE))
        else $error("result overwrote a pending output transaction");

endmodule
